// ===== rtl/servo_angle_command_encoder_unit_assert.svh =====
// ---------------------------------------------------------------------------
// servo angle command encoder assertion macros
// next-cycle implication checks, with and without the reset disable
// ---------------------------------------------------------------------------
`ifndef SERVO_ANGLE_COMMAND_ENCODER_UNIT_ASSERT_SVH
`define SERVO_ANGLE_COMMAND_ENCODER_UNIT_ASSERT_SVH

// implication into the next cycle, switched off while reset is held
`define SACE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sace assertion failed");

// implication into the next cycle, also checked across reset
`define SACE_ASSERT_NEXT_NORST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sace assertion failed");

`endif

// ===== rtl/sace_pkg.sv =====
// ---------------------------------------------------------------------------
// sace_pkg
// types, constants and helper functions of the servo angle command encoder
// ---------------------------------------------------------------------------
package sace_pkg;

    // field widths
    localparam int POSITION_BITS = 13;
    localparam int ANGLE_W       = 16;
    localparam int SERVO_W       = 7;
    localparam int BYTE_W        = 8;
    localparam int LOW_BITS      = 7;
    localparam int CFG_INDEX_W   = 2;

    // accumulator and product widths
    localparam int ACC_W  = 48;
    localparam int PROD_W = ACC_W + ANGLE_W;

    // polynomial coefficients in thousandths, highest power first
    localparam int N_COEF = 6;
    localparam longint PHI_MILLI [N_COEF] = '{9825, -36074, -24022, 20734, 1143982, 2526367};
    localparam longint PSI_MILLI [N_COEF] = '{-9956, 13028, 58822, 5575, 1042237, 2705448};

    // accumulator saturation bounds
    localparam logic signed [PROD_W-1:0] ACC_LIMIT =
        {{(PROD_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] ACC_FLOOR = -ACC_LIMIT;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // command stream framing
    localparam logic [BYTE_W-1:0] CMD_SYNC       = 8'd128;
    localparam logic [BYTE_W-1:0] CMD_SET_TARGET = 8'd4;
    localparam int BYTES_PER_AXIS = 6;
    localparam int BYTES_PER_ITEM = 2 * BYTES_PER_AXIS;
    localparam int BYTE_IDX_W     = $clog2(BYTES_PER_ITEM);
    localparam int SLOT_W         = $clog2(BYTES_PER_AXIS);

    // register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEVICE_NUMBER = 2'd0,
        CFG_PHI_SERVO     = 2'd1,
        CFG_PSI_SERVO     = 2'd2
    } t_cfg_index;

    // byte positions inside one six-byte command
    typedef enum logic [SLOT_W-1:0] {
        SLOT_SYNC     = 3'd0,
        SLOT_DEVICE   = 3'd1,
        SLOT_OPCODE   = 3'd2,
        SLOT_SERVO    = 3'd3,
        SLOT_POS_HIGH = 3'd4,
        SLOT_POS_LOW  = 3'd5
    } t_slot;

    typedef struct packed {
        logic [SERVO_W-1:0] device_number;
        logic [SERVO_W-1:0] phi_servo;
        logic [SERVO_W-1:0] psi_servo;
    } t_cfg;

    typedef struct packed {
        logic                      command;
        logic [POSITION_BITS-1:0]  raw_phi;
        logic [POSITION_BITS-1:0]  raw_psi;
        logic signed [ANGLE_W-1:0] angle_phi;
        logic signed [ANGLE_W-1:0] angle_psi;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_byte;
        logic              clipped;
    } t_out_item;

    typedef struct packed {
        t_in_item                item;
        logic signed [ACC_W-1:0] acc_phi;
        logic signed [ACC_W-1:0] acc_psi;
    } t_work;

    typedef struct packed {
        logic [POSITION_BITS-1:0] pos;
        logic                     clip;
    } t_axis_pos;

    typedef struct packed {
        t_axis_pos phi;
        t_axis_pos psi;
    } t_pos;

    // coefficient in thousandths to fixed point, rounded half away from zero
    function automatic logic signed [ACC_W-1:0] fix_coef(input longint milli, input int frac);
        longint mag;
        longint v;
        mag = (milli < 0) ? -milli : milli;
        v   = ((mag <<< frac) + 64'sd500) / 64'sd1000;
        return ACC_W'((milli < 0) ? -v : v);
    endfunction

    // clamp a horner sum to the accumulator range
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [PROD_W-1:0] v);
        if (v > ACC_LIMIT) begin
            return ACC_LIMIT[ACC_W-1:0];
        end else if (v < ACC_FLOOR) begin
            return ACC_FLOOR[ACC_W-1:0];
        end
        return v[ACC_W-1:0];
    endfunction

endpackage

// ===== rtl/sace_stream_if.sv =====
// ---------------------------------------------------------------------------
// sace_stream_if
// valid/ready stream carrying one payload per transaction
// ---------------------------------------------------------------------------
interface sace_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/sace_horner_step.sv =====
// ---------------------------------------------------------------------------
// sace_horner_step
// one horner step for both axes: multiply stage then shift, add and clamp
// ---------------------------------------------------------------------------
module sace_horner_step #(
    parameter int                                 ANGLE_FRAC_BITS = 14,
    parameter logic signed [sace_pkg::ACC_W-1:0] COEF_PHI        = '0,
    parameter logic signed [sace_pkg::ACC_W-1:0] COEF_PSI        = '0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  sace_pkg::t_work i_data,
    output logic            o_valid,
    output sace_pkg::t_work o_data
);
    import sace_pkg::*;

    logic                     r_valid_a;
    logic                     r_valid_b;
    t_in_item                 r_item_a;
    logic signed [PROD_W-1:0] r_prod_phi;
    logic signed [PROD_W-1:0] r_prod_psi;
    logic signed [PROD_W-1:0] n_prod_phi;
    logic signed [PROD_W-1:0] n_prod_psi;
    t_work                    r_work_b;
    t_work                    n_work_b;

    // stage a: accumulator times angle
    always_comb begin
        n_prod_phi = $signed(i_data.acc_phi) * $signed(i_data.item.angle_phi);
        n_prod_psi = $signed(i_data.acc_psi) * $signed(i_data.item.angle_psi);
    end

    // stage b: floor shift, add next coefficient, clamp
    always_comb begin
        n_work_b.item    = r_item_a;
        n_work_b.acc_phi = sat_acc((r_prod_phi >>> ANGLE_FRAC_BITS) + COEF_PHI);
        n_work_b.acc_psi = sat_acc((r_prod_psi >>> ANGLE_FRAC_BITS) + COEF_PSI);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else if (i_en) begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item_a   <= i_data.item;
            r_prod_phi <= n_prod_phi;
            r_prod_psi <= n_prod_psi;
            r_work_b   <= n_work_b;
        end
    end

    assign o_valid = r_valid_b;
    assign o_data  = r_work_b;
endmodule

// ===== rtl/sace_serializer.sv =====
// ---------------------------------------------------------------------------
// sace_serializer
// turns two axis positions into the twelve-byte command stream
// ---------------------------------------------------------------------------
module sace_serializer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sace_pkg::t_pos i_pos,
    input  sace_pkg::t_cfg i_cfg,
    sace_stream_if.source  o_out
);
    import sace_pkg::*;

    logic                  r_busy;
    logic [BYTE_IDX_W-1:0] r_idx;
    t_pos                  r_pos;
    logic                  w_last;
    logic                  w_take;
    logic                  w_done;
    logic                  w_load;
    logic                  w_second;
    logic [SLOT_W-1:0]     w_slot;
    t_axis_pos             w_axis;
    logic [SERVO_W-1:0]    w_servo;
    logic [BYTE_W-1:0]     w_byte;

    // handshake bookkeeping
    assign w_last  = (r_idx == BYTE_IDX_W'(BYTES_PER_ITEM - 1));
    assign w_take  = r_busy && o_out.ready;
    assign w_done  = w_take && w_last;
    assign o_ready = !r_busy || w_done;
    assign w_load  = i_valid && o_ready;

    // byte counter and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end else if (w_take) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // held positions
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pos <= i_pos;
        end
    end

    // phi command first, psi second
    always_comb begin
        w_second = (r_idx >= BYTE_IDX_W'(BYTES_PER_AXIS));
        w_slot   = w_second ? SLOT_W'(r_idx - BYTE_IDX_W'(BYTES_PER_AXIS)) : SLOT_W'(r_idx);
        w_axis   = w_second ? r_pos.psi : r_pos.phi;
        w_servo  = w_second ? i_cfg.psi_servo : i_cfg.phi_servo;
    end

    // byte select
    always_comb begin
        case (w_slot)
            SLOT_SYNC:     w_byte = CMD_SYNC;
            SLOT_DEVICE:   w_byte = BYTE_W'(i_cfg.device_number);
            SLOT_OPCODE:   w_byte = CMD_SET_TARGET;
            SLOT_SERVO:    w_byte = BYTE_W'(w_servo);
            SLOT_POS_HIGH: w_byte = BYTE_W'(w_axis.pos[POSITION_BITS-1:LOW_BITS]);
            SLOT_POS_LOW:  w_byte = BYTE_W'(w_axis.pos[LOW_BITS-1:0]);
            default:       w_byte = '0;
        endcase
    end

    assign o_out.valid             = r_busy;
    assign o_out.payload.out_byte  = w_byte;
    assign o_out.payload.last_byte = w_last;
    assign o_out.payload.clipped   = w_axis.clip;
endmodule

// ===== rtl/servo_angle_command_encoder_unit.sv =====
// ---------------------------------------------------------------------------
// servo_angle_command_encoder_unit
// two-axis servo position encoder with polynomial angle calibration
// ---------------------------------------------------------------------------
// i_in takes one item per transaction: a mode bit, two raw positions and two
// Q2.14 angles. o_out gives twelve byte transactions per item, the phi
// command then the psi command, last_byte marking the twelfth byte.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data);
// write it only while the block is empty.
// Path from input transaction to first output byte: an input register, five
// two-stage horner steps (multiply, then shift/add/clamp), a position stage,
// then the byte serializer. The serializer emits one byte a cycle while
// o_out is ready, taking a new item as the last byte of the previous is taken;
// the pipeline takes an item every cycle until it fills.
// A stall on o_out holds the current byte. While the position stage holds
// an item that the serializer cannot take yet, every stage holds, bubbles
// included, and i_in.ready is low; nothing is lost or repeated.
// Reset empties the pipeline and the serializer and loads device_number 1,
// phi_servo 0 and psi_servo 1.
// ---------------------------------------------------------------------------
module servo_angle_command_encoder_unit #(
    parameter int ANGLE_FRAC_BITS = 14,
    parameter int COEF_FRAC_BITS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    sace_stream_if.sink                        i_in,
    sace_stream_if.source                      o_out,
    input  logic                               i_cfg_we,
    input  logic [sace_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [sace_pkg::SERVO_W-1:0]       i_cfg_data
);
    import sace_pkg::*;

    localparam logic signed [ACC_W-1:0] PHI_LEAD = fix_coef(PHI_MILLI[0], COEF_FRAC_BITS);
    localparam logic signed [ACC_W-1:0] PSI_LEAD = fix_coef(PSI_MILLI[0], COEF_FRAC_BITS);

    t_cfg              r_cfg;
    logic              r_in_valid;
    t_in_item          r_in_item;
    t_work             w_data [N_COEF];
    logic [N_COEF-1:0] w_valid;
    logic              r_pos_valid;
    t_pos              r_pos;
    t_pos              n_pos;
    logic              w_en;
    logic              w_ser_ready;

    // angle accumulator to a saturated position, truncating toward zero
    function automatic t_axis_pos to_axis(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] q;
        t_axis_pos        res;
        mag = ACC_W'(-acc);
        q   = ACC_W'(acc) >> COEF_FRAC_BITS;
        if (acc[ACC_W-1]) begin
            res.pos  = '0;
            res.clip = ((mag >> COEF_FRAC_BITS) != '0);
        end else if (q > ACC_W'(POS_MAX)) begin
            res.pos  = POS_MAX;
            res.clip = 1'b1;
        end else begin
            res.pos  = q[POSITION_BITS-1:0];
            res.clip = 1'b0;
        end
        return res;
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_number <= SERVO_W'(1);
            r_cfg.phi_servo     <= SERVO_W'(0);
            r_cfg.psi_servo     <= SERVO_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEVICE_NUMBER: r_cfg.device_number <= i_cfg_data;
                CFG_PHI_SERVO:     r_cfg.phi_servo     <= i_cfg_data;
                CFG_PSI_SERVO:     r_cfg.psi_servo     <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // whole pipeline advances unless the position stage is held
    assign w_en       = !r_pos_valid || w_ser_ready;
    assign i_in.ready = w_en;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_en) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_item <= i_in.payload;
        end
    end

    // horner start: leading coefficient
    assign w_valid[0]      = r_in_valid;
    assign w_data[0].item    = r_in_item;
    assign w_data[0].acc_phi = PHI_LEAD;
    assign w_data[0].acc_psi = PSI_LEAD;

    // one step per lower coefficient
    for (genvar g = 1; g < N_COEF; g++) begin : g_step
        sace_horner_step #(
            .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
            .COEF_PHI        (fix_coef(PHI_MILLI[g], COEF_FRAC_BITS)),
            .COEF_PSI        (fix_coef(PSI_MILLI[g], COEF_FRAC_BITS))
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g-1]),
            .i_data  (w_data[g-1]),
            .o_valid (w_valid[g]),
            .o_data  (w_data[g])
        );
    end

    // position stage: raw or calibrated, with clip flags
    always_comb begin
        if (w_data[N_COEF-1].item.command) begin
            n_pos.phi = to_axis(w_data[N_COEF-1].acc_phi);
            n_pos.psi = to_axis(w_data[N_COEF-1].acc_psi);
        end else begin
            n_pos.phi.pos  = w_data[N_COEF-1].item.raw_phi;
            n_pos.phi.clip = 1'b0;
            n_pos.psi.pos  = w_data[N_COEF-1].item.raw_psi;
            n_pos.psi.clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_valid <= 1'b0;
        end else if (w_en) begin
            r_pos_valid <= w_valid[N_COEF-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pos <= n_pos;
        end
    end

    // byte stream out
    sace_serializer u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_pos_valid),
        .o_ready (w_ser_ready),
        .i_pos   (r_pos),
        .i_cfg   (r_cfg),
        .o_out   (o_out)
    );
endmodule

// ===== rtl/sace_checker.sv =====
// ---------------------------------------------------------------------------
// sace_checker
// port-level checks of the byte stream, bound to the top level
// ---------------------------------------------------------------------------
`include "servo_angle_command_encoder_unit_assert.svh"

module sace_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [sace_pkg::BYTE_W-1:0]   i_out_byte,
    input logic                          i_out_last,
    input logic                          i_out_clipped
);
    import sace_pkg::*;

    // a stalled byte holds
    `SACE_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_out_last) && $stable(i_out_clipped))

    // nothing is offered straight after reset
    `SACE_ASSERT_NEXT_NORST(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)

    // a new item always opens with the sync byte
    `SACE_ASSERT_NEXT(a_sync_after_last, i_clk, i_rst_n, i_out_valid && i_out_ready && i_out_last, !i_out_valid || (i_out_byte == CMD_SYNC && !i_out_last))
endmodule

bind servo_angle_command_encoder_unit sace_checker u_sace_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_byte    (o_out.payload.out_byte),
    .i_out_last    (o_out.payload.last_byte),
    .i_out_clipped (o_out.payload.clipped)
);

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the servo angle command encoder: an item driver and
// a byte monitor with random idling on both sides, a shadow of the three
// registers and a bit-exact model of the calibration and framing that
// predicts the twelve command bytes of every item taken
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sace_pkg::*;

    localparam int ANGLE_FRAC     = 14;
    localparam int COEF_FRAC      = 16;
    localparam int ANGLE_LIMIT    = 25736;
    localparam longint ACC_MAX    = (longint'(1) << 47) - 1;
    localparam int DRAIN_CYCLES   = 24;
    localparam int CYCLE_LIMIT    = 1_500_000;
    localparam int N_PHASES       = 6;
    localparam int ITEMS_PER_PHASE = 65;
    localparam int REPORT_LIMIT   = 10;

    // index past the last register, writes to it must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    // calibration coefficients in thousandths, highest power first
    localparam longint PHI_COEF_MILLI [6] = '{9825, -36074, -24022, 20734, 1143982, 2526367};
    localparam longint PSI_COEF_MILLI [6] = '{-9956, 13028, 58822, 5575, 1042237, 2705448};

    // idle percentages per random phase, sender and receiver
    localparam int SRC_IDLE_PCT  [N_PHASES] = '{0, 30, 70, 10, 0, 50};
    localparam int SINK_IDLE_PCT [N_PHASES] = '{0, 70, 30, 0, 50, 20};

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [SERVO_W-1:0]     i_cfg_data;

    sace_stream_if #(.t_payload(t_in_item))  item_ch ();
    sace_stream_if #(.t_payload(t_out_item)) byte_ch ();

    t_in_item  pending_items [$];
    t_out_item expected_bytes [$];
    t_cfg      cfg_shadow;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int gap_left;
    int stall_left;
    int mismatch_count = 0;
    int cycle_count    = 0;

    servo_angle_command_encoder_unit #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC),
        .COEF_FRAC_BITS (COEF_FRAC)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (item_ch),
        .o_out      (byte_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // coefficient to fixed point, rounded half away from zero
    function automatic longint coef_fixed(input longint milli);
        longint mag;
        longint v;
        mag = (milli < 0) ? -milli : milli;
        v   = ((mag << COEF_FRAC) + 500) / 1000;
        return (milli < 0) ? -v : v;
    endfunction

    // horner evaluation of one axis, truncation and saturation to a position
    function automatic t_axis_pos calibrate_axis(input logic use_psi,
                                                 input logic signed [ANGLE_W-1:0] angle);
        longint    acc;
        longint    milli;
        longint    whole;
        t_axis_pos res;
        acc = coef_fixed(use_psi ? PSI_COEF_MILLI[0] : PHI_COEF_MILLI[0]);
        for (int k = 1; k < 6; k++) begin
            milli = use_psi ? PSI_COEF_MILLI[k] : PHI_COEF_MILLI[k];
            acc   = ((acc * longint'(angle)) >>> ANGLE_FRAC) + coef_fixed(milli);
            if (acc > ACC_MAX) begin
                acc = ACC_MAX;
            end else if (acc < -ACC_MAX) begin
                acc = -ACC_MAX;
            end
        end
        // truncate toward zero
        if (acc < 0) begin
            whole = -((-acc) >>> COEF_FRAC);
        end else begin
            whole = acc >>> COEF_FRAC;
        end
        res.clip = 1'b0;
        if (whole < 0) begin
            res.clip = 1'b1;
            res.pos  = '0;
        end else if (whole > longint'(POS_MAX)) begin
            res.clip = 1'b1;
            res.pos  = POS_MAX;
        end else begin
            res.pos = POSITION_BITS'(whole);
        end
        return res;
    endfunction

    // six bytes of one absolute-position command
    function automatic void queue_axis_command(input logic [SERVO_W-1:0] servo,
                                               input t_axis_pos p, input logic ends_item);
        t_out_item b;
        for (int s = 0; s < BYTES_PER_AXIS; s++) begin
            case (t_slot'(s))
                SLOT_SYNC:     b.out_byte = CMD_SYNC;
                SLOT_DEVICE:   b.out_byte = {1'b0, cfg_shadow.device_number};
                SLOT_OPCODE:   b.out_byte = CMD_SET_TARGET;
                SLOT_SERVO:    b.out_byte = {1'b0, servo};
                SLOT_POS_HIGH: b.out_byte = {2'b00, p.pos[POSITION_BITS-1:LOW_BITS]};
                default:       b.out_byte = {1'b0, p.pos[LOW_BITS-1:0]};
            endcase
            b.last_byte = ends_item && (t_slot'(s) == SLOT_POS_LOW);
            b.clipped   = p.clip;
            expected_bytes.push_back(b);
        end
    endfunction

    // expected byte stream of one accepted item
    function automatic void predict_item_bytes(input t_in_item it);
        t_axis_pos phi_p;
        t_axis_pos psi_p;
        if (it.command) begin
            phi_p = calibrate_axis(1'b0, it.angle_phi);
            psi_p = calibrate_axis(1'b1, it.angle_psi);
        end else begin
            phi_p.pos  = it.raw_phi;
            phi_p.clip = 1'b0;
            psi_p.pos  = it.raw_psi;
            psi_p.clip = 1'b0;
        end
        queue_axis_command(cfg_shadow.phi_servo, phi_p, 1'b0);
        queue_axis_command(cfg_shadow.psi_servo, psi_p, 1'b1);
    endfunction

    function automatic t_in_item make_item(input logic cmd,
                                           input logic [POSITION_BITS-1:0] rphi,
                                           input logic [POSITION_BITS-1:0] rpsi,
                                           input int aphi, input int apsi);
        t_in_item it;
        it.command   = cmd;
        it.raw_phi   = rphi;
        it.raw_psi   = rpsi;
        it.angle_phi = ANGLE_W'(aphi);
        it.angle_psi = ANGLE_W'(apsi);
        return it;
    endfunction

    function automatic logic [POSITION_BITS-1:0] random_position();
        case ($urandom_range(9))
            0:       return '0;
            1:       return POS_MAX;
            default: return POSITION_BITS'($urandom_range(int'(POS_MAX)));
        endcase
    endfunction

    // mostly inside the working range, some at its ends, some any 16-bit word
    function automatic int random_angle();
        int r;
        r = $urandom_range(19);
        if (r < 2) begin
            return (r == 0) ? ANGLE_LIMIT : -ANGLE_LIMIT;
        end else if (r < 5) begin
            return int'($urandom_range(65535)) - 32768;
        end
        return int'($urandom_range(2 * ANGLE_LIMIT)) - ANGLE_LIMIT;
    endfunction

    function automatic t_in_item random_item();
        return make_item(1'($urandom_range(1)), random_position(), random_position(),
                         random_angle(), random_angle());
    endfunction

    // idle length: none, mostly short, now and then long
    function automatic int pick_idle(input int pct);
        if (int'($urandom_range(99)) >= pct) begin
            return 0;
        end else if ($urandom_range(7) == 0) begin
            return $urandom_range(40, 10);
        end
        return $urandom_range(3, 1);
    endfunction

    function automatic void report_mismatch(input string what, input t_out_item exp_b,
                                            input t_out_item act_b);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t mismatch (%s): expected byte %0d last %0b clipped %0b, got byte %0d last %0b clipped %0b",
                     $realtime, what, exp_b.out_byte, exp_b.last_byte, exp_b.clipped,
                     act_b.out_byte, act_b.last_byte, act_b.clipped);
        end
    endfunction

    // item driver: predicts on each transaction, then loads the next item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid   <= 1'b0;
            item_ch.payload <= '0;
            gap_left        <= 0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                predict_item_bytes(item_ch.payload);
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left      <= gap_left - 1;
                    item_ch.valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    item_ch.valid   <= 1'b1;
                    item_ch.payload <= pending_items.pop_front();
                    gap_left        <= pick_idle(src_idle_pct);
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // byte monitor: checks each transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item exp_b;
        if (!i_rst_n) begin
            byte_ch.ready <= 1'b0;
            stall_left    <= 0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("unexpected byte", '0, byte_ch.payload);
                end else begin
                    exp_b = expected_bytes.pop_front();
                    if (byte_ch.payload.out_byte !== exp_b.out_byte
                            || byte_ch.payload.last_byte !== exp_b.last_byte
                            || byte_ch.payload.clipped !== exp_b.clipped) begin
                        report_mismatch("wrong field", exp_b, byte_ch.payload);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left    <= stall_left - 1;
                byte_ch.ready <= 1'b0;
            end else begin
                byte_ch.ready <= 1'b1;
                stall_left    <= pick_idle(sink_idle_pct);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // register write, shadow kept in step
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [SERVO_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_DEVICE_NUMBER: cfg_shadow.device_number = val;
            CFG_PHI_SERVO:     cfg_shadow.phi_servo     = val;
            CFG_PSI_SERVO:     cfg_shadow.psi_servo     = val;
            default: ;
        endcase
    endtask

    // wait until every item is taken and every byte has arrived, then settle
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_items.size() != 0 || item_ch.valid || expected_bytes.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // stimulus sequence
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        byte_ch.ready   = 1'b0;
        cfg_shadow.device_number = 7'd1;
        cfg_shadow.phi_servo     = 7'd0;
        cfg_shadow.psi_servo     = 7'd1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed items under the reset register values
        pending_items.push_back(make_item(1'b0, '0, '0, 0, 0));
        pending_items.push_back(make_item(1'b0, POS_MAX, POS_MAX, -1, -1));
        pending_items.push_back(make_item(1'b0, 13'h1555, 13'h0AAA, 21845, -21846));
        pending_items.push_back(make_item(1'b0, 13'h0AAA, 13'h1555, -21846, 21845));
        pending_items.push_back(make_item(1'b0, POS_MAX, '0, 32767, -32768));
        pending_items.push_back(make_item(1'b1, POS_MAX, POS_MAX, 0, 0));
        pending_items.push_back(make_item(1'b1, '0, '0, ANGLE_LIMIT, ANGLE_LIMIT));
        pending_items.push_back(make_item(1'b1, '0, '0, -ANGLE_LIMIT, -ANGLE_LIMIT));
        pending_items.push_back(make_item(1'b1, 13'h1555, 13'h0AAA, -ANGLE_LIMIT, ANGLE_LIMIT));
        pending_items.push_back(make_item(1'b1, '0, '0, 32767, 32767));
        // far negative angle drives the phi curve below zero
        pending_items.push_back(make_item(1'b1, '0, '0, -32768, -32768));
        pending_items.push_back(make_item(1'b1, '0, '0, -30000, 30000));
        pending_items.push_back(make_item(1'b1, '0, '0, 16384, -16384));
        pending_items.push_back(make_item(1'b1, '0, '0, 1, -1));
        pending_items.push_back(make_item(1'b1, '0, '0, 21845, -21846));
        pending_items.push_back(make_item(1'b1, '0, '0, -21846, 21845));
        pending_items.push_back(make_item(1'b1, '0, '0, -20000, 8192));
        wait_drained();

        // random phases, each under its own register setting and idling
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    write_register(CFG_DEVICE_NUMBER, 7'd127);
                    write_register(CFG_PHI_SERVO, 7'd127);
                    write_register(CFG_PSI_SERVO, 7'd0);
                end
                1: begin
                    write_register(CFG_DEVICE_NUMBER, 7'd0);
                    write_register(CFG_PHI_SERVO, 7'd0);
                    write_register(CFG_PSI_SERVO, 7'd127);
                end
                default: begin
                    write_register(CFG_DEVICE_NUMBER, 7'($urandom));
                    write_register(CFG_PHI_SERVO, 7'($urandom));
                    write_register(CFG_PSI_SERVO, 7'($urandom));
                end
            endcase
            if (ph >= 2) begin
                write_register(CFG_SPARE_INDEX, 7'($urandom));
            end
            @(negedge i_clk);
            src_idle_pct  = SRC_IDLE_PCT[ph];
            sink_idle_pct = SINK_IDLE_PCT[ph];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pending_items.push_back(random_item());
            end
            wait_drained();
        end

        if (mismatch_count == 0 && expected_bytes.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
